// ===== sv/caws_pkg.sv =====
// Shared types and operation codes for the 8-bit ALU with status flags.
package caws_pkg;

  // Operation codes carried by each input beat
  typedef enum logic [4:0] {
    OP_ADC   = 5'd0,
    OP_SBC   = 5'd1,
    OP_AND   = 5'd2,
    OP_ORA   = 5'd3,
    OP_EOR   = 5'd4,
    OP_BIT   = 5'd5,
    OP_CMP   = 5'd6,
    OP_ASL_A = 5'd7,
    OP_LSR_A = 5'd8,
    OP_ROL_A = 5'd9,
    OP_ROR_A = 5'd10,
    OP_ASL_M = 5'd11,
    OP_LSR_M = 5'd12,
    OP_ROL_M = 5'd13,
    OP_ROR_M = 5'd14,
    OP_INC_M = 5'd15,
    OP_DEC_M = 5'd16
  } op_e;

  localparam logic [7:0] SignBit = 8'b1000_0000;
  localparam logic [7:0] OvfBit  = 8'b0100_0000;
  localparam logic [7:0] LowBit  = 8'b0000_0001;

  // Architectural state: accumulator and flags
  typedef struct packed {
    logic [7:0] acc;
    logic       carry;
    logic       zero;
    logic       overflow;
    logic       negative;
  } arch_t;

  // One input beat as held in the input register
  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  operand;
    logic [7:0]  compare_register;
    logic [15:0] address;
  } item_t;

  // Memory write-back produced by the execute logic
  typedef struct packed {
    logic       write;
    logic [7:0] data;
  } mem_wb_t;

endpackage

// ===== sv/caws_in_stage.sv =====
// Input register stage: captures one beat and holds it until it advances.
module caws_in_stage import caws_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;

  // Take a new beat when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/caws_exec.sv =====
// Execute logic: next accumulator, flags and memory write-back for one beat.
module caws_exec import caws_pkg::*; (
  input  item_t   item_i,
  input  arch_t   state_i,
  output arch_t   state_o,
  output mem_wb_t wb_o
);

  op_e        op;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] shift_src;
  logic [7:0] shift_res;
  logic       shift_out;
  logic [7:0] res;

  assign op = op_e'(item_i.operation);

  // Shared adder for ADC and SBC: SBC adds the inverted operand
  assign addend = (op == OP_SBC) ? ~item_i.operand : item_i.operand;
  assign sum    = {1'b0, state_i.acc} + {1'b0, addend} + {8'd0, state_i.carry};

  // Compare: register minus operand, carry out means no borrow
  assign diff = {1'b0, item_i.compare_register} + {1'b0, ~item_i.operand} + 9'd1;

  // Shift and rotate unit, fed from the accumulator or the fetched byte
  assign shift_src = ((op == OP_ASL_A) || (op == OP_LSR_A) || (op == OP_ROL_A) ||
                      (op == OP_ROR_A)) ? state_i.acc : item_i.operand;

  always_comb begin
    shift_res = shift_src;
    shift_out = state_i.carry;
    case (op)
      OP_ASL_A, OP_ASL_M: begin
        shift_res = {shift_src[6:0], 1'b0};
        shift_out = |(shift_src & SignBit);
      end
      OP_LSR_A, OP_LSR_M: begin
        shift_res = {1'b0, shift_src[7:1]};
        shift_out = |(shift_src & LowBit);
      end
      OP_ROL_A, OP_ROL_M: begin
        shift_res = {shift_src[6:0], state_i.carry};
        shift_out = |(shift_src & SignBit);
      end
      OP_ROR_A, OP_ROR_M: begin
        shift_res = {state_i.carry, shift_src[7:1]};
        shift_out = |(shift_src & LowBit);
      end
      default: begin
        shift_res = shift_src;
        shift_out = state_i.carry;
      end
    endcase
  end

  // Select the result and update state per operation
  always_comb begin
    state_o = state_i;
    wb_o    = '0;
    res     = state_i.acc;
    unique case (op)
      OP_ADC, OP_SBC: begin
        res              = sum[7:0];
        state_o.acc      = res;
        state_o.carry    = sum[8];
        state_o.overflow = |(~(state_i.acc ^ addend) & (state_i.acc ^ res) & SignBit);
        state_o.zero     = (res == 8'd0);
        state_o.negative = |(res & SignBit);
      end
      OP_AND, OP_ORA, OP_EOR: begin
        if (op == OP_AND) begin
          res = state_i.acc & item_i.operand;
        end else if (op == OP_ORA) begin
          res = state_i.acc | item_i.operand;
        end else begin
          res = state_i.acc ^ item_i.operand;
        end
        state_o.acc      = res;
        state_o.zero     = (res == 8'd0);
        state_o.negative = |(res & SignBit);
      end
      OP_BIT: begin
        state_o.zero     = ((state_i.acc & item_i.operand) == 8'd0);
        state_o.overflow = |(item_i.operand & OvfBit);
        state_o.negative = |(item_i.operand & SignBit);
      end
      OP_CMP: begin
        state_o.carry    = diff[8];
        state_o.zero     = (item_i.compare_register == item_i.operand);
        state_o.negative = diff[7];
      end
      OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
        state_o.acc      = shift_res;
        state_o.carry    = shift_out;
        state_o.zero     = (shift_res == 8'd0);
        state_o.negative = |(shift_res & SignBit);
      end
      OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
        wb_o.write       = 1'b1;
        wb_o.data        = shift_res;
        state_o.carry    = shift_out;
        state_o.zero     = (shift_res == 8'd0);
        state_o.negative = |(shift_res & SignBit);
      end
      OP_INC_M, OP_DEC_M: begin
        if (op == OP_INC_M) begin
          res = item_i.operand + 8'd1;
        end else begin
          res = item_i.operand - 8'd1;
        end
        wb_o.write       = 1'b1;
        wb_o.data        = res;
        state_o.zero     = (res == 8'd0);
        state_o.negative = |(res & SignBit);
      end
      default: begin
        // Unknown code: keep state, report it unchanged
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== sv/cpu_alu_with_status_flags.sv =====
// Pipeline: an input beat passes the input register, then the result register.
// Throughput: one beat per cycle while results are taken; accumulator and carry feed back
// through the execute logic between the input register and the architectural state.
// A result waiting on the output stalls a held beat; an empty input register still fills.
// Reset: rst_ni (async, active low) clears the accumulator, all flags and both valids.
module cpu_alu_with_status_flags import caws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  operation_i,
  input  logic [7:0]  operand_i,
  input  logic [7:0]  compare_register_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  accumulator_out_o,
  output logic        memory_write_o,
  output logic [7:0]  memory_data_o,
  output logic [15:0] memory_address_o,
  output logic        carry_flag_o,
  output logic        zero_flag_o,
  output logic        overflow_flag_o,
  output logic        negative_flag_o
);

  item_t   item_in;
  item_t   item_s1;
  logic    valid_s1;
  logic    advance;
  arch_t   state_q;
  arch_t   state_d;
  mem_wb_t wb;
  logic    out_valid_q;
  logic    out_valid_d;
  arch_t   out_state_q;
  mem_wb_t out_wb_q;
  logic [15:0] out_addr_q;

  assign item_in = '{operation: operation_i, operand: operand_i,
                     compare_register: compare_register_i, address: address_i};

  // Held beat moves to the result register when that register is free or draining
  assign advance = valid_s1 && (!out_valid_q || out_ready_i);

  caws_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (valid_s1),
    .item_o     (item_s1)
  );

  caws_exec u_exec (
    .item_i  (item_s1),
    .state_i (state_q),
    .state_o (state_d),
    .wb_o    (wb)
  );

  // Commit accumulator and flags as each beat advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result valid: set on advance, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_state_q <= state_d;
      out_wb_q    <= wb;
      out_addr_q  <= wb.write ? item_s1.address : 16'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accumulator_out_o = out_state_q.acc;
  assign memory_write_o    = out_wb_q.write;
  assign memory_data_o     = out_wb_q.data;
  assign memory_address_o  = out_addr_q;
  assign carry_flag_o      = out_state_q.carry;
  assign zero_flag_o       = out_state_q.zero;
  assign overflow_flag_o   = out_state_q.overflow;
  assign negative_flag_o   = out_state_q.negative;

endmodule
